>>> rtl/wgf_pkg.sv
// Shared types, constants and arithmetic helpers for the wheel ground friction step unit.
`default_nettype none

package wgf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Skid queue between front and back (power of two).
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [30:0] RST_TIME_STEP      = 31'd655;
    localparam logic [30:0] RST_FRICTION_COEFF = 31'd42598;
    localparam logic [30:0] RST_WHEEL_INERTIA  = 31'd6554;
    localparam logic [30:0] RST_SHAFT_DAMPING  = 31'd65536;

    typedef enum logic [1:0] {
        REG_TIME_STEP      = 2'd0,
        REG_FRICTION_COEFF = 2'd1,
        REG_WHEEL_INERTIA  = 2'd2,
        REG_SHAFT_DAMPING  = 2'd3
    } t_reg;

    typedef struct packed {
        logic [30:0] time_step;
        logic [30:0] friction_coeff;
        logic [30:0] wheel_inertia;
        logic [30:0] shaft_damping;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [30:0] normal_load;
        logic        [30:0] wheel_diameter;
        logic signed [31:0] spin_rate;
        logic signed [31:0] drive_torque;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_lon;
        logic signed [31:0] force_lat;
        logic signed [31:0] new_spin_rate;
    } t_out;

    // Queue entry: item fields plus the raw front products.
    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin_rate;
        logic signed [31:0] drive_torque;
        logic        [30:0] wheel_diameter;
        logic        [61:0] prod_lim;
        logic signed [63:0] prod_damp;
    } t_qent;

    // Sideband riding along the tw divider.
    typedef struct packed {
        logic signed [31:0] damp;
        logic signed [31:0] w;
        logic signed [31:0] tq;
        logic        [30:0] diam;
    } t_bside;

    // Per-item context carried down the back pipeline.
    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] lim;
        logic signed [31:0] damp;
        logic signed [31:0] w;
        logic signed [31:0] tq;
        logic        [30:0] diam;
    } t_ctx;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Fixed-point product rescale, floor rounding, saturated.
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p,
                                                  input int unsigned s);
        logic signed [63:0] t;
        t = p >>> s;
        return sat32(t);
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [31:0] x,
                                                 input logic signed [31:0] lim);
        logic signed [31:0] r;
        if (x > lim) begin
            r = lim;
        end else if (x < -lim) begin
            r = -lim;
        end else begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] r;
        r = x[31] ? (~$unsigned(x) + 32'd1) : $unsigned(x);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wgf_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed saturating result.
`default_nettype none

module wgf_div #(
    parameter int NW = 49,
    parameter int SW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic                 i_neg,
    input  wire logic [NW-1:0]        i_mag,
    input  wire logic [30:0]          i_den,
    input  wire logic [SW-1:0]        i_side,
    output logic                      o_vld,
    output logic signed [31:0]        o_quo,
    output logic [SW-1:0]             o_side
);

    logic          s_vld  [NW+1];
    logic          s_neg  [NW+1];
    logic          s_zero [NW+1];
    logic [NW-1:0] s_w    [NW+1];
    logic [30:0]   s_rem  [NW+1];
    logic [30:0]   s_den  [NW+1];
    logic [SW-1:0] s_side [NW+1];

    assign s_vld[0]  = i_vld;
    assign s_neg[0]  = i_neg;
    assign s_zero[0] = (i_mag == '0);
    assign s_w[0]    = i_mag;
    assign s_rem[0]  = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    // Dividend bits shift out of the top of w while quotient bits shift in at the bottom.
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [31:0]   trial;
        logic          ge;
        logic          r_vld;
        logic          r_neg;
        logic          r_zero;
        logic [NW-1:0] r_w;
        logic [30:0]   r_rem;
        logic [30:0]   r_den;
        logic [SW-1:0] r_side;

        assign trial = {s_rem[k], s_w[k][NW-1]};
        assign ge    = (trial >= {1'b0, s_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w    <= {s_w[k][NW-2:0], ge};
                r_rem  <= ge ? 31'(trial - {1'b0, s_den[k]}) : trial[30:0];
                r_neg  <= s_neg[k];
                r_zero <= s_zero[k];
                r_den  <= s_den[k];
                r_side <= s_side[k];
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_neg[k+1]  = r_neg;
        assign s_zero[k+1] = r_zero;
        assign s_w[k+1]    = r_w;
        assign s_rem[k+1]  = r_rem;
        assign s_den[k+1]  = r_den;
        assign s_side[k+1] = r_side;
    end

    // Zero divisor yields an all-ones quotient, which saturates by sign; a zero dividend gives zero.
    always_comb begin
        logic signed [63:0] ext;
        logic signed [63:0] val;
        ext = $signed({{(64-NW){1'b0}}, s_w[NW]});
        val = s_neg[NW] ? -ext : ext;
        o_quo = s_zero[NW] ? 32'sd0 : wgf_pkg::sat32(val);
    end

    assign o_vld  = s_vld[NW];
    assign o_side = s_side[NW];

endmodule

`default_nettype wire

>>> rtl/wgf_queue.sv
// Small FIFO between the front and back sections.
`default_nettype none

module wgf_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire wgf_pkg::t_qent                  i_ent,
    input  wire logic                            i_pop,
    output wgf_pkg::t_qent                       o_ent,
    output logic [wgf_pkg::QCNT_W-1:0]           o_count
);

    wgf_pkg::t_qent                  r_mem [wgf_pkg::QDEPTH];
    logic [wgf_pkg::QPTR_W-1:0]      r_wr;
    logic [wgf_pkg::QPTR_W-1:0]      r_rd;
    logic [wgf_pkg::QCNT_W-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    assign o_ent   = r_mem[r_rd];
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> rtl/wgf_front.sv
// Front section: takes items, forms the load-limit and damping products, feeds the queue.
`default_nettype none

module wgf_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire wgf_pkg::t_in                 i_item,
    input  wire wgf_pkg::t_cfg                i_cfg,
    input  wire logic [wgf_pkg::QCNT_W-1:0]   i_q_count,
    output logic                              o_push,
    output wgf_pkg::t_qent                    o_ent
);

    logic                       r1_vld;
    wgf_pkg::t_in               r1_item;
    logic                       r2_vld;
    wgf_pkg::t_qent             r2_ent;
    wgf_pkg::t_qent             n2_ent;
    logic [wgf_pkg::QCNT_W:0]   s_pending;
    logic                       s_accept;

    // Items already in the two front stages are counted against queue space.
    assign s_pending = {1'b0, i_q_count} + (wgf_pkg::QCNT_W+1)'(r1_vld)
                     + (wgf_pkg::QCNT_W+1)'(r2_vld);
    assign o_stall   = (s_pending >= (wgf_pkg::QCNT_W+1)'(wgf_pkg::QDEPTH));
    assign s_accept  = i_valid && !o_stall;

    always_comb begin
        n2_ent.vel_x          = r1_item.vel_x;
        n2_ent.vel_y          = r1_item.vel_y;
        n2_ent.spin_rate      = r1_item.spin_rate;
        n2_ent.drive_torque   = r1_item.drive_torque;
        n2_ent.wheel_diameter = r1_item.wheel_diameter;
        n2_ent.prod_lim       = r1_item.normal_load * i_cfg.friction_coeff;
        n2_ent.prod_damp      = $signed({1'b0, i_cfg.shaft_damping}) * r1_item.spin_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= s_accept;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r1_item <= i_item;
        end
        r2_ent <= n2_ent;
    end

    assign o_push = r2_vld;
    assign o_ent  = r2_ent;

endmodule

`default_nettype wire

>>> rtl/wgf_back.sv
// Back section: divider chain and force / spin update pipeline with output register.
`default_nettype none

module wgf_back #(
    parameter int FRAC_BITS = wgf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire wgf_pkg::t_cfg                i_cfg,
    input  wire logic [wgf_pkg::QCNT_W-1:0]   i_q_count,
    input  wire wgf_pkg::t_qent               i_ent,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output wgf_pkg::t_out                     o_result
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int BW = $bits(wgf_pkg::t_bside);
    localparam int CW = $bits(wgf_pkg::t_ctx);

    logic s_adv;
    logic s_pop;

    logic signed [31:0] s_lim;
    logic signed [31:0] s_damp;
    wgf_pkg::t_bside    s_bside_in;

    logic               a_vld;
    logic signed [31:0] a_quo;
    logic [31:0]        a_side;
    logic               b_vld;
    logic signed [31:0] b_quo;
    logic [BW-1:0]      b_side;
    wgf_pkg::t_bside    s_bside;
    logic               c_vld;
    logic signed [31:0] c_quo;
    logic [CW-1:0]      c_side;
    logic               d_vld;
    logic signed [31:0] d_quo;
    logic [CW-1:0]      d_side;
    logic               e_vld;
    logic signed [31:0] e_quo;
    logic [CW-1:0]      e_side;

    logic               r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic               r6_vld, r7_vld, r8_vld, r9_vld, r10_vld;
    logic               r_out_vld;
    wgf_pkg::t_ctx      r1_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx;
    wgf_pkg::t_ctx      r6_ctx, r7_ctx, r8_ctx, r9_ctx, r10_ctx;
    wgf_pkg::t_ctx      n1_ctx, n5_ctx;
    wgf_pkg::t_ctx      s_cctx, s_dctx, s_ectx;
    logic signed [31:0] r1_dw;
    logic signed [63:0] r2_prod;
    logic signed [31:0] r3_inert;
    logic signed [31:0] r4_num;
    logic signed [63:0] r6_prod;
    logic signed [31:0] r7_rf;
    logic signed [31:0] r8_num2;
    logic signed [63:0] r9_prod;
    logic signed [31:0] r10_dw2;
    wgf_pkg::t_out      r_out;

    // Whole back pipeline moves when the output register can take a result.
    assign s_adv = !r_out_vld || !i_stall;
    assign s_pop = s_adv && (i_q_count != '0);
    assign o_pop = s_pop;

    assign s_lim  = wgf_pkg::qscale($signed({2'b00, i_ent.prod_lim}), FRAC_BITS);
    assign s_damp = wgf_pkg::qscale(i_ent.prod_damp, FRAC_BITS);

    always_comb begin
        s_bside_in.damp = s_damp;
        s_bside_in.w    = i_ent.spin_rate;
        s_bside_in.tq   = i_ent.drive_torque;
        s_bside_in.diam = i_ent.wheel_diameter;
    end

    // Lateral: -vy/dt
    wgf_div #(.NW(NW), .SW(32)) u_div_lat (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_adv),
        .i_vld  (s_pop),
        .i_neg  (!i_ent.vel_y[31]),
        .i_mag  (NW'(wgf_pkg::mag32(i_ent.vel_y)) << FRAC_BITS),
        .i_den  (i_cfg.time_step),
        .i_side (s_lim),
        .o_vld  (a_vld),
        .o_quo  (a_quo),
        .o_side (a_side)
    );

    // No-slip spin target: 2vx/diam
    wgf_div #(.NW(NW), .SW(BW)) u_div_tw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_adv),
        .i_vld  (s_pop),
        .i_neg  (i_ent.vel_x[31]),
        .i_mag  (NW'(wgf_pkg::mag32(i_ent.vel_x)) << (FRAC_BITS + 1)),
        .i_den  (i_ent.wheel_diameter),
        .i_side (s_bside_in),
        .o_vld  (b_vld),
        .o_quo  (b_quo),
        .o_side (b_side)
    );

    assign s_bside = wgf_pkg::t_bside'(b_side);

    always_comb begin
        n1_ctx.lat  = a_quo;
        n1_ctx.lon  = '0;
        n1_ctx.lim  = a_side;
        n1_ctx.damp = s_bside.damp;
        n1_ctx.w    = s_bside.w;
        n1_ctx.tq   = s_bside.tq;
        n1_ctx.diam = s_bside.diam;
    end

    // Angular acceleration toward target: (tw - w)/dt
    wgf_div #(.NW(NW), .SW(CW)) u_div_alpha (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_adv),
        .i_vld  (r1_vld),
        .i_neg  (r1_dw[31]),
        .i_mag  (NW'(wgf_pkg::mag32(r1_dw)) << FRAC_BITS),
        .i_den  (i_cfg.time_step),
        .i_side (r1_ctx),
        .o_vld  (c_vld),
        .o_quo  (c_quo),
        .o_side (c_side)
    );

    assign s_cctx = wgf_pkg::t_ctx'(c_side);

    // Longitudinal force: 2num/diam
    wgf_div #(.NW(NW), .SW(CW)) u_div_lon (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_adv),
        .i_vld  (r4_vld),
        .i_neg  (r4_num[31]),
        .i_mag  (NW'(wgf_pkg::mag32(r4_num)) << (FRAC_BITS + 1)),
        .i_den  (r4_ctx.diam),
        .i_side (r4_ctx),
        .o_vld  (d_vld),
        .o_quo  (d_quo),
        .o_side (d_side)
    );

    assign s_dctx = wgf_pkg::t_ctx'(d_side);

    always_comb begin
        n5_ctx     = s_dctx;
        n5_ctx.lon = wgf_pkg::clamp(d_quo, s_dctx.lim);
        n5_ctx.lat = wgf_pkg::clamp(s_dctx.lat, s_dctx.lim);
    end

    // Spin acceleration: num2/Iyy
    wgf_div #(.NW(NW), .SW(CW)) u_div_alpha2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (s_adv),
        .i_vld  (r8_vld),
        .i_neg  (r8_num2[31]),
        .i_mag  (NW'(wgf_pkg::mag32(r8_num2)) << FRAC_BITS),
        .i_den  (i_cfg.wheel_inertia),
        .i_side (r8_ctx),
        .o_vld  (e_vld),
        .o_quo  (e_quo),
        .o_side (e_side)
    );

    assign s_ectx = wgf_pkg::t_ctx'(e_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (s_adv) begin
            r1_vld    <= a_vld && b_vld;
            r2_vld    <= c_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= d_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= e_vld;
            r10_vld   <= r9_vld;
            r_out_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r1_ctx   <= n1_ctx;
            r1_dw    <= wgf_pkg::sat32(64'(b_quo) - 64'(s_bside.w));
            r2_ctx   <= s_cctx;
            r2_prod  <= $signed({1'b0, i_cfg.wheel_inertia}) * c_quo;
            r3_ctx   <= r2_ctx;
            r3_inert <= wgf_pkg::qscale(r2_prod, FRAC_BITS);
            r4_ctx   <= r3_ctx;
            r4_num   <= wgf_pkg::sat32(64'(r3_ctx.tq) - 64'(r3_inert) - 64'(r3_ctx.damp));
            r5_ctx   <= n5_ctx;
            r6_ctx   <= r5_ctx;
            r6_prod  <= $signed({1'b0, r5_ctx.diam}) * r5_ctx.lon;
            r7_ctx   <= r6_ctx;
            r7_rf    <= wgf_pkg::qscale(r6_prod, FRAC_BITS + 1);
            r8_ctx   <= r7_ctx;
            r8_num2  <= wgf_pkg::sat32(64'(r7_ctx.tq) - 64'(r7_rf) - 64'(r7_ctx.damp));
            r9_ctx   <= s_ectx;
            r9_prod  <= e_quo * $signed({1'b0, i_cfg.time_step});
            r10_ctx  <= r9_ctx;
            r10_dw2  <= wgf_pkg::qscale(r9_prod, FRAC_BITS);
            r_out.force_lon     <= r10_ctx.lon;
            r_out.force_lat     <= r10_ctx.lat;
            r_out.new_spin_rate <= wgf_pkg::sat32(64'(r10_ctx.w) + 64'(r10_dw2));
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> rtl/wheel_ground_friction_step_unit.sv
// Top level of the wheel ground friction step unit: config registers, front, queue, back.
`default_nettype none

// Per-wheel ground friction for one time step in signed fixed point (FRAC_BITS fraction
// bits). One item per clock is taken in steady state unless the output stalls; each item
// yields exactly one result, after passing four dependent pipelined dividers (one quotient
// bit per stage) in the back section.
// A 4-entry queue separates the front from the back; while a result waits on the output
// the back holds and the input side takes items only until the queue is full. Registers
// live at byte addresses 0, 4, 8, 12:
// time_step, friction_coeff, wheel_inertia, shaft_damping (31 bits, upper bit ignored).
// Write them only while the unit is idle.
module wheel_ground_friction_step_unit #(
    parameter int FRAC_BITS = wgf_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire wgf_pkg::t_in  i_item,
    output logic               o_valid,
    input  wire logic          i_stall,
    output wgf_pkg::t_out      o_result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    wgf_pkg::t_cfg                    r_cfg;
    logic                             s_wr;
    logic                             s_push;
    logic                             s_pop;
    wgf_pkg::t_qent                   s_push_ent;
    wgf_pkg::t_qent                   s_head;
    logic [wgf_pkg::QCNT_W-1:0]       s_q_count;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step      <= wgf_pkg::RST_TIME_STEP;
            r_cfg.friction_coeff <= wgf_pkg::RST_FRICTION_COEFF;
            r_cfg.wheel_inertia  <= wgf_pkg::RST_WHEEL_INERTIA;
            r_cfg.shaft_damping  <= wgf_pkg::RST_SHAFT_DAMPING;
        end else if (s_wr) begin
            unique case (wgf_pkg::t_reg'(paddr[3:2]))
                wgf_pkg::REG_TIME_STEP:      r_cfg.time_step      <= pwdata[30:0];
                wgf_pkg::REG_FRICTION_COEFF: r_cfg.friction_coeff <= pwdata[30:0];
                wgf_pkg::REG_WHEEL_INERTIA:  r_cfg.wheel_inertia  <= pwdata[30:0];
                wgf_pkg::REG_SHAFT_DAMPING:  r_cfg.shaft_damping  <= pwdata[30:0];
                default:                     r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (wgf_pkg::t_reg'(paddr[3:2]))
            wgf_pkg::REG_TIME_STEP:      prdata = {1'b0, r_cfg.time_step};
            wgf_pkg::REG_FRICTION_COEFF: prdata = {1'b0, r_cfg.friction_coeff};
            wgf_pkg::REG_WHEEL_INERTIA:  prdata = {1'b0, r_cfg.wheel_inertia};
            wgf_pkg::REG_SHAFT_DAMPING:  prdata = {1'b0, r_cfg.shaft_damping};
            default:                     prdata = '0;
        endcase
    end

    wgf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_count(s_q_count),
        .o_push   (s_push),
        .o_ent    (s_push_ent)
    );

    wgf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_push),
        .i_ent  (s_push_ent),
        .i_pop  (s_pop),
        .o_ent  (s_head),
        .o_count(s_q_count)
    );

    wgf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_count(s_q_count),
        .i_ent    (s_head),
        .o_pop    (s_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_count <= wgf_pkg::QCNT_W'(wgf_pkg::QDEPTH))
        else $error("queue count above depth");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_q_count == wgf_pkg::QCNT_W'(wgf_pkg::QDEPTH)) |-> o_stall)
        else $error("input not stalled with queue full");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_wr && paddr[3:2] == wgf_pkg::REG_TIME_STEP)
        |=> (r_cfg.time_step == $past(pwdata[30:0])))
        else $error("time_step write lost");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the wheel ground friction step unit.
`timescale 1ns / 100ps

module testbench;

    localparam int FB = wgf_pkg::FRAC_BITS_DEF;
    localparam int SETTLE = 4 * (FB + 33) + 40;
    localparam int WATCH_LIMIT = 20000;

    // Expected-force store plus the force model.
    class friction_board;
        bit [30:0] dt, mu, iyy, damp_c;
        wgf_pkg::t_out pending[$];
        int errors;
        int checked;

        function new();
            dt = wgf_pkg::RST_TIME_STEP;
            mu = wgf_pkg::RST_FRICTION_COEFF;
            iyy = wgf_pkg::RST_WHEEL_INERTIA;
            damp_c = wgf_pkg::RST_SHAFT_DAMPING;
            errors = 0;
            checked = 0;
        endfunction

        function longint sat(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint floor_shift(longint x, int s);
            return x >>> s;
        endfunction

        function longint quot(longint n, longint d);
            if (d == 0) return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
            return sat(n / d);
        endfunction

        function longint fmul(longint a, longint b, int s);
            return sat(floor_shift(a * b, s));
        endfunction

        function longint limit_to(longint x, longint lim);
            if (x > lim) return lim;
            if (x < -lim) return -lim;
            return x;
        endfunction

        function void note_item(wgf_pkg::t_in it);
            longint one, vx, vy, ld, dm, w, tq, lim, lat, tw, dw, alpha;
            longint inert, dmp, num, lon, rf, num2, alpha2, dw2, nw;
            wgf_pkg::t_out r;
            one = 64'sd1 << FB;
            vx = it.vel_x; vy = it.vel_y; w = it.spin_rate; tq = it.drive_torque;
            ld = {33'd0, it.normal_load};
            dm = {33'd0, it.wheel_diameter};
            lim = fmul({33'd0, mu}, ld, FB);
            lat = limit_to(quot(-vy * one, {33'd0, dt}), lim);
            tw = quot(vx * one * 2, dm);
            dw = sat(tw - w);
            alpha = quot(dw * one, {33'd0, dt});
            inert = fmul({33'd0, iyy}, alpha, FB);
            dmp = fmul({33'd0, damp_c}, w, FB);
            num = sat(tq - inert - dmp);
            lon = limit_to(quot(num * one * 2, dm), lim);
            rf = fmul(dm, lon, FB + 1);
            num2 = sat(tq - rf - dmp);
            alpha2 = quot(num2 * one, {33'd0, iyy});
            dw2 = fmul(alpha2, {33'd0, dt}, FB);
            nw = sat(w + dw2);
            r.force_lon = lon[31:0];
            r.force_lat = lat[31:0];
            r.new_spin_rate = nw[31:0];
            pending = {pending, r};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
        endtask

        task check_result(wgf_pkg::t_out got);
            wgf_pkg::t_out want;
            if (pending.size() == 0) begin
                report("unexpected result", got.force_lon, 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.force_lon !== want.force_lon)
                report("force_lon", got.force_lon, want.force_lon);
            if (got.force_lat !== want.force_lat)
                report("force_lat", got.force_lat, want.force_lat);
            if (got.new_spin_rate !== want.new_spin_rate)
                report("new_spin_rate", got.new_spin_rate, want.new_spin_rate);
            checked++;
        endtask
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    wgf_pkg::t_in i_item;
    wgf_pkg::t_out o_result;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    wheel_ground_friction_step_unit dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item, .o_valid, .i_stall, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    friction_board board;
    int send_idle_pct, recv_stall_pct;
    int quiet_cycles;
    int sent;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: random stall, check each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_result);
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("FAIL wheel_ground_friction_step_unit");
            $finish;
        end
    end

    task automatic write_reg(wgf_pkg::t_reg idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            wgf_pkg::REG_TIME_STEP:      board.dt = val[30:0];
            wgf_pkg::REG_FRICTION_COEFF: board.mu = val[30:0];
            wgf_pkg::REG_WHEEL_INERTIA:  board.iyy = val[30:0];
            wgf_pkg::REG_SHAFT_DAMPING:  board.damp_c = val[30:0];
        endcase
    endtask

    // Drop valid and wait for every expected result.
    task automatic wait_empty();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Present one item, hold until transferred; valid stays up for the next item.
    task automatic send_item(wgf_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_item(it);
        sent++;
    endtask

    function automatic logic [31:0] rnd_s32();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3FFFF)
                                           : -$urandom_range(0, 32'h3FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rnd_u31(bit nonzero);
        logic [30:0] v;
        case ($urandom_range(4))
            0: v = 31'h7FFFFFFF;
            1: v = nonzero ? 31'd1 : 31'd0;
            2: v = 31'($urandom_range(1, 32'h3FFFF));
            default: v = 31'($urandom);
        endcase
        if (nonzero && v == 0) v = 1;
        return v;
    endfunction

    function automatic wgf_pkg::t_in rnd_item();
        wgf_pkg::t_in it;
        it.vel_x = rnd_s32();
        it.vel_y = rnd_s32();
        it.normal_load = rnd_u31(0);
        it.wheel_diameter = rnd_u31(1);
        it.spin_rate = rnd_s32();
        it.drive_torque = rnd_s32();
        return it;
    endfunction

    task automatic random_cfg();
        write_reg(wgf_pkg::REG_TIME_STEP, {1'b0, rnd_u31(1)});
        write_reg(wgf_pkg::REG_FRICTION_COEFF, {1'($urandom_range(1)), rnd_u31(0)});
        write_reg(wgf_pkg::REG_WHEEL_INERTIA, {1'b0, rnd_u31(1)});
        write_reg(wgf_pkg::REG_SHAFT_DAMPING, {1'($urandom_range(1)), rnd_u31(0)});
    endtask

    initial begin
        wgf_pkg::t_in it;
        board = new();
        i_rst_n = 0; i_valid = 0; i_item = '0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0; sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: field extremes at reset settings, then extreme registers.
        it = '{32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'd1, 32'h80000000, 32'h7FFFFFFF};
        send_item(it);
        it = '{32'h80000000, 32'h7FFFFFFF, 31'd0, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        send_item(it);
        it = '{32'd0, 32'd0, 31'd65536, 31'd65536, 32'd0, 32'd0};
        send_item(it);
        it = '{32'd65536, -32'sd65536, 31'd655360, 31'd32768, 32'd131072, 32'd6554};
        send_item(it);
        drain();
        write_reg(wgf_pkg::REG_TIME_STEP, 32'd1);
        write_reg(wgf_pkg::REG_FRICTION_COEFF, 32'hFFFFFFFF);
        write_reg(wgf_pkg::REG_WHEEL_INERTIA, 32'd1);
        write_reg(wgf_pkg::REG_SHAFT_DAMPING, 32'd0);
        repeat (8) send_item(rnd_item());
        drain();
        write_reg(wgf_pkg::REG_TIME_STEP, 32'h7FFFFFFF);
        write_reg(wgf_pkg::REG_FRICTION_COEFF, 32'd0);
        write_reg(wgf_pkg::REG_WHEEL_INERTIA, 32'h7FFFFFFF);
        write_reg(wgf_pkg::REG_SHAFT_DAMPING, 32'h7FFFFFFF);
        repeat (8) send_item(rnd_item());
        drain();

        // Random phases: sender-light idling, receiver-heavy, then swapped, then none.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 8; recv_stall_pct = 88; end
                1: begin send_idle_pct = 88; recv_stall_pct = 8; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 2) begin
                write_reg(wgf_pkg::REG_TIME_STEP, {1'b0, wgf_pkg::RST_TIME_STEP});
                write_reg(wgf_pkg::REG_FRICTION_COEFF, {1'b0, wgf_pkg::RST_FRICTION_COEFF});
                write_reg(wgf_pkg::REG_WHEEL_INERTIA, {1'b0, wgf_pkg::RST_WHEEL_INERTIA});
                write_reg(wgf_pkg::REG_SHAFT_DAMPING, {1'b0, wgf_pkg::RST_SHAFT_DAMPING});
            end else begin
                random_cfg();
            end
            for (int k = 0; k < 310; k++) begin
                send_item(rnd_item());
                if (k == 150) wait_empty();
            end
            drain();
        end

        $display("covered %0d items over several register settings, %0d results checked",
                 sent, board.checked);
        $display("idling mixes: sender-light, receiver-light and none");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS wheel_ground_friction_step_unit");
        else
            $display("FAIL wheel_ground_friction_step_unit");
        $finish;
    end
endmodule
